// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every edge outside reset
`define DIRW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define DIRW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DIRW_ASSERT(label, clk, rst, prop)
`define DIRW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/dirw_pkg.sv =====
// ----------------------------------------------------------------------------
// dirw_pkg
// types, constants and codes shared by the row warp block
// ----------------------------------------------------------------------------
package dirw_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int COL_W      = 11;  // column counter and read column
  localparam int COLOR_W    = 24;
  localparam int DEPTH_W    = 8;
  localparam int BASE_W     = 11;
  localparam int IMG_W      = 12;
  localparam int WORD_W     = COLOR_W + DEPTH_W;
  localparam int PROD_W     = 20;  // (depth - far) * baseline
  localparam int DEN_W      = 9;   // near - far, signed
  localparam int NUM_MAG_W  = 18;  // magnitude of the product
  localparam int DIV_MAG_W  = 8;   // magnitude of the denominator
  localparam int QUO_W      = 19;  // signed shift
  localparam int TGT_W      = 20;  // signed target column
  localparam int DIV_CNT_W  = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_NEAR  = 2'd0,
    CFG_DEPTH_FAR   = 2'd1,
    CFG_BASELINE    = 2'd2,
    CFG_IMAGE_WIDTH = 2'd3
  } cfg_idx_t;

  localparam logic [DEPTH_W-1:0] DEPTH_NEAR_RST  = 8'd255;
  localparam logic [DEPTH_W-1:0] DEPTH_FAR_RST   = 8'd0;
  localparam logic [BASE_W-1:0]  BASELINE_RST    = 11'd0;
  localparam logic [IMG_W-1:0]   IMAGE_WIDTH_RST = 12'd2048;

  typedef enum logic {
    FUNC_WARP = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic [COLOR_W-1:0] pixel_color;
    logic [DEPTH_W-1:0] pixel_depth;
    logic               row_end;
    logic [COL_W-1:0]   read_column;
  } req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] out_color;
    logic [DEPTH_W-1:0] out_depth;
    logic               is_hole;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_WLOOK,
    ST_WUPD,
    ST_RLOOK,
    ST_RDONE
  } state_t;

  typedef struct packed {
    logic capture;    // take the request payload
    logic clear_wr;   // write one zero slot of the reset sweep
    logic mul_load;   // register product and denominator
    logic div_start;  // start the divider
    logic tgt_load;   // register target column and range check
    logic wr_look;    // read the slot at the target
    logic wr_upd;     // depth test and store
    logic rd_look;    // read the slot at the read column
    logic rd_done;    // load the result and clear the slot
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic clear_last;
  } sts_t;

endpackage

// ===== design/dirw_ram.sv =====
// ----------------------------------------------------------------------------
// dirw_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dirw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dirw_div.sv =====
// ----------------------------------------------------------------------------
// dirw_div
// restoring divider on magnitudes, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dirw_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dirw_pkg::NUM_MAG_W-1:0] dividend,
  input  logic [dirw_pkg::DIV_MAG_W-1:0] divisor,
  output logic                           busy,
  output logic [dirw_pkg::NUM_MAG_W-1:0] quotient
);

  localparam int NW = dirw_pkg::NUM_MAG_W;
  localparam int DW = dirw_pkg::DIV_MAG_W;
  localparam int CW = dirw_pkg::DIV_CNT_W;

  logic [CW-1:0] count;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [NW-1:0] dq;    // dividend shifts out, quotient shifts in

  logic [DW:0]   trial;
  logic          fits;

  always_comb begin
    trial = {rem, dq[NW-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CW'(NW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dq  <= dividend;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
      dq  <= {dq[NW-2:0], fits};
    end
  end

  assign quotient = dq;

  `DIRW_ASSERT_NEXT(a_start_busy, clk, rst, start, busy)
  `DIRW_ASSERT(a_count_bound, clk, rst, !busy || (count < CW'(NW)))

endmodule

// ===== design/dirw_ctrl.sv =====
// ----------------------------------------------------------------------------
// dirw_ctrl
// sequencer for reset sweep, warp and read items, and the result handshake
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dirw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_func,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output dirw_pkg::cmd_t   cmd,
  input  dirw_pkg::sts_t   sts
);

  dirw_pkg::state_t state;
  dirw_pkg::state_t state_next;
  logic             rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dirw_pkg::ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      dirw_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = dirw_pkg::ST_IDLE;
        end
      end
      dirw_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = (req_func == dirw_pkg::FUNC_READ) ? dirw_pkg::ST_RLOOK
                                                          : dirw_pkg::ST_MUL;
        end
      end
      dirw_pkg::ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = dirw_pkg::ST_DSTART;
      end
      dirw_pkg::ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = dirw_pkg::ST_DIV;
      end
      dirw_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.tgt_load = 1'b1;
          state_next   = dirw_pkg::ST_WLOOK;
        end
      end
      dirw_pkg::ST_WLOOK: begin
        cmd.wr_look = 1'b1;
        state_next  = dirw_pkg::ST_WUPD;
      end
      dirw_pkg::ST_WUPD: begin
        cmd.wr_upd = 1'b1;
        state_next = dirw_pkg::ST_IDLE;
      end
      dirw_pkg::ST_RLOOK: begin
        cmd.rd_look = 1'b1;
        state_next  = dirw_pkg::ST_RDONE;
      end
      dirw_pkg::ST_RDONE: begin
        // hold until the output register is free or being emptied
        if (!rsp_valid || rsp_ready) begin
          cmd.rd_done = 1'b1;
          state_next  = dirw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dirw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.rd_done) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  `DIRW_ASSERT(a_rise_from_read, clk, rst, !$rose(rsp_valid) || $past(state == dirw_pkg::ST_RDONE))
  `DIRW_ASSERT(a_div_idle_start, clk, rst, !cmd.div_start || sts.div_done)
  `DIRW_ASSERT(a_no_rsp_in_clear, clk, rst, (state != dirw_pkg::ST_CLEAR) || !rsp_valid)

endmodule

// ===== design/dirw_dp.sv =====
// ----------------------------------------------------------------------------
// dirw_dp
// datapath: config registers, shift arithmetic, row buffer and result register
// ----------------------------------------------------------------------------
module dirw_dp #(
  parameter int MAX_WIDTH = dirw_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dirw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dirw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  dirw_pkg::req_t                  req,
  output dirw_pkg::rsp_t                  rsp,
  input  dirw_pkg::cmd_t                  cmd,
  output dirw_pkg::sts_t                  sts
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int RW     = (AW + 1 > 12) ? AW + 1 : 12;  // read column compare width
  localparam int COL_W  = dirw_pkg::COL_W;
  localparam int CLR_W  = dirw_pkg::COLOR_W;
  localparam int DEP_W  = dirw_pkg::DEPTH_W;
  localparam int PW     = dirw_pkg::PROD_W;
  localparam int DENW   = dirw_pkg::DEN_W;
  localparam int NMW    = dirw_pkg::NUM_MAG_W;
  localparam int DMW    = dirw_pkg::DIV_MAG_W;
  localparam int QW     = dirw_pkg::QUO_W;
  localparam int TW     = dirw_pkg::TGT_W;

  // configuration
  logic [DEP_W-1:0]               depth_near;
  logic [DEP_W-1:0]               depth_far;
  logic signed [dirw_pkg::BASE_W-1:0] baseline;
  logic [dirw_pkg::IMG_W-1:0]     image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_near  <= dirw_pkg::DEPTH_NEAR_RST;
      depth_far   <= dirw_pkg::DEPTH_FAR_RST;
      baseline    <= dirw_pkg::BASELINE_RST;
      image_width <= dirw_pkg::IMAGE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (dirw_pkg::cfg_idx_t'(cfg_index))
        dirw_pkg::CFG_DEPTH_NEAR:  depth_near  <= cfg_data[DEP_W-1:0];
        dirw_pkg::CFG_DEPTH_FAR:   depth_far   <= cfg_data[DEP_W-1:0];
        dirw_pkg::CFG_BASELINE:    baseline    <= cfg_data[dirw_pkg::BASE_W-1:0];
        dirw_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // column counter and reset sweep address
  logic [COL_W-1:0] col;
  logic [AW-1:0]    clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.capture && (req.func == dirw_pkg::FUNC_WARP)) begin
        col <= req.row_end ? '0 : col + 1'b1;
      end
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign sts.clear_last = (clr_addr == AW'(MAX_WIDTH - 1));

  // captured item
  logic [CLR_W-1:0] cap_color;
  logic [DEP_W-1:0] cap_depth;
  logic [COL_W-1:0] cap_col;
  logic [COL_W-1:0] cap_rcol;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_color <= req.pixel_color;
      cap_depth <= req.pixel_depth;
      cap_col   <= col;
      cap_rcol  <= req.read_column;
    end
  end

  // product and denominator
  logic signed [DENW-1:0] diff;
  logic signed [DENW-1:0] den_next;
  logic signed [PW-1:0]   prod_next;
  logic signed [PW-1:0]   prod;
  logic signed [DENW-1:0] den;

  always_comb begin
    diff      = $signed({1'b0, cap_depth}) - $signed({1'b0, depth_far});
    den_next  = $signed({1'b0, depth_near}) - $signed({1'b0, depth_far});
    prod_next = diff * baseline;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= prod_next;
      den  <= den_next;
    end
  end

  logic [PW-1:0]   prod_abs;
  logic [DENW-1:0] den_abs;
  logic            q_neg;
  logic            den_zero;
  logic            div_busy;
  logic [NMW-1:0]  q_mag;

  always_comb begin
    prod_abs = prod[PW-1] ? PW'(-prod) : prod;
    den_abs  = den[DENW-1] ? DENW'(-den) : den;
    q_neg    = prod[PW-1] ^ den[DENW-1];
    den_zero = (den == '0);
  end

  dirw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_abs[NMW-1:0]),
    .divisor  (den_abs[DMW-1:0]),
    .busy     (div_busy),
    .quotient (q_mag)
  );

  assign sts.div_done = !div_busy;

  // target column and range check
  logic signed [QW-1:0] shift;
  logic signed [TW-1:0] target;
  logic [TW-2:0]        lim_img;
  logic [TW-2:0]        lim_max;
  logic [TW-2:0]        lim;
  logic                 tgt_ok;
  logic [AW-1:0]        tgt_addr;
  logic                 tgt_in;

  always_comb begin
    if (den_zero) begin
      shift = '0;
    end else if (q_neg) begin
      shift = -$signed({1'b0, q_mag});
    end else begin
      shift = $signed({1'b0, q_mag});
    end
    target  = $signed({{(TW - COL_W){1'b0}}, cap_col}) + TW'(shift);
    lim_img = (TW - 1)'(image_width);
    lim_max = (TW - 1)'(MAX_WIDTH);
    lim     = (lim_img < lim_max) ? lim_img : lim_max;
    tgt_ok  = !target[TW-1] && (target[TW-2:0] < lim);
  end

  always_ff @(posedge clk) begin
    if (cmd.tgt_load) begin
      tgt_addr <= target[AW-1:0];
      tgt_in   <= tgt_ok;
    end
  end

  // read column range
  logic [RW-1:0] rd_ext;
  logic          rd_in;
  logic [AW-1:0] rd_addr;

  always_comb begin
    rd_ext  = RW'(cap_rcol);
    rd_in   = rd_ext < RW'(MAX_WIDTH);
    rd_addr = rd_ext[AW-1:0];
  end

  // row buffer, one word holds colour and depth
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [dirw_pkg::WORD_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [dirw_pkg::WORD_W-1:0] ram_rdata;
  logic [CLR_W-1:0]           slot_color;
  logic [DEP_W-1:0]           slot_depth;

  assign slot_color = ram_rdata[dirw_pkg::WORD_W-1:DEP_W];
  assign slot_depth = ram_rdata[DEP_W-1:0];

  always_comb begin
    ram_re    = cmd.wr_look || cmd.rd_look;
    ram_raddr = cmd.wr_look ? tgt_addr : rd_addr;
    ram_we    = 1'b0;
    ram_waddr = rd_addr;
    ram_wdata = '0;
    priority if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (cmd.wr_upd) begin
      // z-buffer: fill a hole or overwrite a farther pixel
      ram_we    = tgt_in && ((slot_color == '0) || (slot_depth < cap_depth));
      ram_waddr = tgt_addr;
      ram_wdata = {cap_color, cap_depth};
    end else if (cmd.rd_done) begin
      ram_we    = rd_in;
      ram_waddr = rd_addr;
    end else begin
      ram_we    = 1'b0;
    end
  end

  dirw_ram #(
    .WIDTH (dirw_pkg::WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.rd_done) begin
      rsp.out_color <= rd_in ? slot_color : '0;
      rsp.out_depth <= rd_in ? slot_depth : '0;
      rsp.is_hole   <= !rd_in || (slot_color == '0);
    end
  end

endmodule

// ===== design/depth_image_row_warp.sv =====
// Depth-image row warp with a z-buffer. After reset the block first zeroes its
// row buffer, one slot per cycle, and takes no items until the sweep is done
// (configuration writes are taken throughout). A warp item (func 0) takes the
// running column counter, computes the shift
// trunc((depth - depth_far) * baseline / (depth_near - depth_far)) with a
// registered multiply and an 18-step restoring divider, and stores colour and
// depth at column + shift when that column is inside min(image_width,
// MAX_WIDTH) and the slot is a hole or holds a smaller depth; it gives no
// result. It holds the block through the multiply, divider start, divide,
// look-up and update states; the divider yields one quotient bit a cycle. A
// read item (func 1) returns one slot, flags it as a hole when its colour is
// zero or its column is beyond the buffer, and clears it; it waits in its
// done state while the previous result still holds the output register. Items
// are handled one at a time; a new item is taken while an earlier result waits.
// ----------------------------------------------------------------------------
// depth_image_row_warp
// top level: horizontal depth-image-based rendering of one row
// ----------------------------------------------------------------------------
module depth_image_row_warp #(
  parameter int MAX_WIDTH = dirw_pkg::MAX_WIDTH_DEF  // row buffer slots, 16 to 8192
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [dirw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dirw_pkg::CFG_DATA_W-1:0] cfg_data,
  // item channel
  input  logic                            req_valid,
  output logic                            req_ready,
  input  dirw_pkg::req_t                  req,
  // result channel
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output dirw_pkg::rsp_t                  rsp
);

  // commands from the sequencer, status back from the datapath
  dirw_pkg::cmd_t cmd;
  dirw_pkg::sts_t sts;

  // sequencer: reset sweep, warp and read steps, output register handshake
  dirw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: config, shift arithmetic, row buffer ram, result register
  dirw_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== sim/dirw_slot_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dirw_slot_checker
// watches the config port and both item channels of the row warp block,
// keeps its own z-buffered row and column counter, and compares every
// read result with the slot it predicts
// ----------------------------------------------------------------------------
module dirw_slot_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dirw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dirw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  dirw_pkg::req_t                  req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  dirw_pkg::rsp_t                  rsp,
  output int                              errors,
  output int                              pending,
  output int                              warps,
  output int                              landed,
  output int                              reads,
  output int                              holes
);
  import dirw_pkg::*;

  localparam int SLOTS = MAX_WIDTH_DEF;

  logic [COLOR_W-1:0]      slot_color [SLOTS];
  logic [DEPTH_W-1:0]      slot_depth [SLOTS];
  logic [COL_W-1:0]        column;
  logic [DEPTH_W-1:0]      near_q;
  logic [DEPTH_W-1:0]      far_q;
  logic signed [BASE_W-1:0] base_q;
  logic [IMG_W-1:0]        width_q;

  rsp_t expected_slots [$];

  int n_err    = 0;
  int n_warp   = 0;
  int n_landed = 0;
  int n_read   = 0;
  int n_hole   = 0;

  // trunc((depth - far) * baseline / (near - far)), zero when near == far
  function automatic int shift_for(input logic [DEPTH_W-1:0] d);
    int den;
    int num;
    den = int'(near_q) - int'(far_q);
    if (den == 0) return 0;
    num = (int'(d) - int'(far_q)) * int'(base_q);
    return num / den;
  endfunction

  task automatic place_pixel(input req_t r);
    int lim;
    int target;
    lim    = (int'(width_q) > SLOTS) ? SLOTS : int'(width_q);
    target = int'(column) + shift_for(r.pixel_depth);
    if (target >= 0 && target < lim) begin
      if (slot_color[target] == '0 || slot_depth[target] < r.pixel_depth) begin
        slot_color[target] = r.pixel_color;
        slot_depth[target] = r.pixel_depth;
        n_landed++;
      end
    end
    column = r.row_end ? '0 : column + 1'b1;
  endtask

  // read returns the slot and clears it
  task automatic take_slot(input logic [COL_W-1:0] col);
    rsp_t e;
    e.out_color = slot_color[col];
    e.out_depth = slot_depth[col];
    e.is_hole   = (slot_color[col] == '0);
    if (e.is_hole) n_hole++;
    slot_color[col] = '0;
    slot_depth[col] = '0;
    expected_slots.push_back(e);
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t e;
    if (expected_slots.size() == 0) begin
      n_err++;
      $display("%0t: result with nothing expected, expected none got %h", $time, got);
      return;
    end
    e = expected_slots.pop_front();
    if (got.out_color !== e.out_color) begin
      n_err++;
      $display("%0t: out_color expected %h got %h", $time, e.out_color, got.out_color);
    end
    if (got.out_depth !== e.out_depth) begin
      n_err++;
      $display("%0t: out_depth expected %h got %h", $time, e.out_depth, got.out_depth);
    end
    if (got.is_hole !== e.is_hole) begin
      n_err++;
      $display("%0t: is_hole expected %b got %b", $time, e.is_hole, got.is_hole);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_color[i] = '0;
        slot_depth[i] = '0;
      end
      column  = '0;
      near_q  = DEPTH_NEAR_RST;
      far_q   = DEPTH_FAR_RST;
      base_q  = BASELINE_RST;
      width_q = IMAGE_WIDTH_RST;
      expected_slots.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEPTH_NEAR:  near_q  = cfg_data[DEPTH_W-1:0];
          CFG_DEPTH_FAR:   far_q   = cfg_data[DEPTH_W-1:0];
          CFG_BASELINE:    base_q  = cfg_data[BASE_W-1:0];
          CFG_IMAGE_WIDTH: width_q = cfg_data[IMG_W-1:0];
          default: ;
        endcase
      end
      // results leave before a new read is queued in the same cycle
      if (rsp_valid && rsp_ready) check_result(rsp);
      if (req_valid && req_ready) begin
        if (req.func == FUNC_READ) begin
          n_read++;
          take_slot(req.read_column);
        end else begin
          n_warp++;
          place_pixel(req);
        end
      end
    end
    errors  <= n_err;
    pending <= expected_slots.size();
    warps   <= n_warp;
    landed  <= n_landed;
    reads   <= n_read;
    holes   <= n_hole;
  end

endmodule

// ===== sim/tb_depth_image_row_warp.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_image_row_warp
// drives warp and read items into the row warp block through a series of
// register settings, with random idling on both channels, and leaves all
// prediction and comparison to the slot checker
// ----------------------------------------------------------------------------
module tb_depth_image_row_warp;
  import dirw_pkg::*;

  // the clear sweep after reset alone moves no item
  localparam int STALL_LIMIT   = 20000;
  // a warp item keeps the block busy with no result to show it
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 122;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  cfg_idx_t              cfg_index = CFG_DEPTH_NEAR;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  req_valid = 1'b0;
  req_t                  req       = '0;
  logic                  rsp_ready = 1'b0;
  logic                  req_ready;
  logic                  rsp_valid;
  rsp_t                  rsp;

  // idle odds in percent, set per phase
  int   send_idle   = 23;
  int   recv_idle   = 59;
  logic start_hold  = 1'b0;
  int   hold_left   = 0;
  int   idle_cycles = 0;
  int   sent        = 0;
  int   settings    = 0;

  int errors, pending, warps, landed, reads, holes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  depth_image_row_warp u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  dirw_slot_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .warps     (warps),
    .landed    (landed),
    .reads     (reads),
    .holes     (holes)
  );

  // receiver: random ready, or a long hold-off counted here once asked for
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
    end else if (start_hold) begin
      rsp_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_depth_image_row_warp: done, errors");
      $finish;
    end
  end

  // offer one item, idling first at the phase odds, and wait for acceptance
  task automatic send_item(input req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  // read fields ride along with random content
  task automatic send_warp(input logic [COLOR_W-1:0] color, input logic [DEPTH_W-1:0] depth,
                           input logic last);
    req_t r;
    r.func        = FUNC_WARP;
    r.pixel_color = color;
    r.pixel_depth = depth;
    r.row_end     = last;
    r.read_column = COL_W'($urandom);
    send_item(r);
  endtask

  task automatic send_read(input logic [COL_W-1:0] col);
    req_t r;
    r.func        = FUNC_READ;
    r.pixel_color = COLOR_W'($urandom);
    r.pixel_depth = DEPTH_W'($urandom);
    r.row_end     = 1'($urandom);
    r.read_column = col;
    send_item(r);
  endtask

  // stop offering, wait for every result, then let a warp in flight finish
  task automatic settle;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers on consecutive cycles
  task automatic program_regs(input int near, input int far, input int base, input int width);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEPTH_NEAR;
    cfg_data  <= CFG_DATA_W'(near);
    @(posedge clk);
    cfg_index <= CFG_DEPTH_FAR;
    cfg_data  <= CFG_DATA_W'(far);
    @(posedge clk);
    cfg_index <= CFG_BASELINE;
    cfg_data  <= {1'b0, BASE_W'(base)};
    @(posedge clk);
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(width);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // extremes first, then random spans with small rows and modest shifts
  task automatic phase_regs(input int p);
    case (p)
      0:       program_regs(255, 0, 8, 32);
      1:       program_regs(0, 255, -1024, 4095);
      2:       program_regs(77, 77, 1023, 20);
      3:       program_regs(255, 254, 1023, 2048);
      4:       program_regs(0, 0, -1024, 1);
      default: program_regs($urandom_range(0, 255), $urandom_range(0, 255),
                            int'($urandom_range(0, 40)) - 20, $urandom_range(4, 40));
    endcase
  endtask

  // one row of pixels ending in row_end, then reads around where they landed
  task automatic row_then_reads;
    int len;
    int nrd;
    logic [COLOR_W-1:0] color;
    len = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      color = ($urandom_range(0, 9) == 0) ? '0 : COLOR_W'($urandom);
      send_warp(color, DEPTH_W'($urandom), i == len - 1);
    end
    nrd = $urandom_range(1, len + 2);
    for (int i = 0; i < nrd; i++) send_read(COL_W'($urandom_range(0, len + 8)));
  endtask

  // anything the fields allow, including stray row_end and far columns
  task automatic noise_item;
    req_t r;
    r.func        = 1'($urandom);
    r.pixel_color = COLOR_W'($urandom);
    r.pixel_depth = DEPTH_W'($urandom);
    r.row_end     = 1'($urandom);
    r.read_column = COL_W'($urandom);
    send_item(r);
  endtask

  initial begin
    int goal;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings give zero shift: z-test, colour-zero pixel, read clears
    send_warp(24'hFFFFFF, 8'd255, 1'b0);
    send_warp(24'h000000, 8'd0, 1'b0);
    send_warp(24'h5A5A5A, 8'd40, 1'b1);
    send_warp(24'h000001, 8'd20, 1'b0);  // farther pixel loses
    send_warp(24'h000002, 8'd0, 1'b0);   // slot still a hole, taken
    send_warp(24'hA5A5A5, 8'd41, 1'b1);  // nearer pixel wins
    send_read(11'd0);
    send_read(11'd1);
    send_read(11'd2);
    send_read(11'd2047);
    send_read(11'd0);                    // cleared by the first read
    settle();

    // equal near and far, width above the buffer size
    program_regs(100, 100, 1023, 4095);
    send_warp(24'hC0FFEE, 8'd200, 1'b1);
    send_read(11'd0);
    settle();

    // near below far: signed division, depth beyond the span
    program_regs(10, 200, -1024, 2048);
    send_warp(24'h111111, 8'd255, 1'b0);
    send_warp(24'h222222, 8'd205, 1'b1);
    send_read(11'd296);
    send_read(11'd27);
    settle();

    // zero width drops every pixel
    program_regs(255, 0, 1023, 0);
    send_warp(24'h333333, 8'd255, 1'b1);
    send_read(11'd0);
    settle();

    // one column in use: second pixel falls outside
    program_regs(255, 0, -1024, 1);
    send_warp(24'h444444, 8'd0, 1'b0);
    send_warp(24'h555555, 8'd0, 1'b1);
    send_read(11'd0);
    send_read(11'd1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p < 4) begin
        send_idle = 23;
        recv_idle = 59;
      end else if (p < 8) begin
        send_idle = 59;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      phase_regs(p);
      goal = sent + PHASE_ITEMS;

      if (p == 5) begin
        // receiver holds off while reads pile up behind the output register
        send_idle = 0;
        start_hold <= 1'b1;
        @(posedge clk);
        start_hold <= 1'b0;
        for (int i = 0; i < 12; i++) send_read(COL_W'($urandom_range(0, 63)));
        // then the sender waits for the backlog to clear
        settle();
        send_idle = 59;
      end

      while (sent < goal) begin
        if ($urandom_range(0, 99) < 70) row_then_reads();
        else noise_item();
      end
    end

    settle();
    $display("%0d items over %0d register settings: %0d warps, %0d placed in the row",
             sent, settings, warps, landed);
    $display("%0d reads checked, %0d of them holes", reads, holes);
    if (errors == 0 && pending == 0) begin
      $display("tb_depth_image_row_warp: done, clean");
    end else begin
      $display("tb_depth_image_row_warp: done, errors");
    end
    $finish;
  end

endmodule
